// ----- src/channel_sample_history_store_top_macros.svh -----
// assertion macros for the channel sample history store
`ifndef CHANNEL_SAMPLE_HISTORY_STORE_TOP_MACROS_SVH
`define CHANNEL_SAMPLE_HISTORY_STORE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset is sampled
`define CSH_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ----- src/csh_pkg.sv -----
// shared types, codes and defaults for the channel sample history store
package csh_pkg;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int POOL_WORDS_DEF   = 256;
  localparam int MAX_HISTORY_DEF  = 16;
  localparam int DATA_WIDTH_DEF   = 32;

  localparam int REQ_W     = 2;
  localparam int CHAN_ID_W = 16;
  localparam int DEPTH_W   = 7;
  localparam int SAMPLE_W  = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 6;

  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LATEST   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_HISTORY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRESH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_REQ  = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic [CHAN_ID_W-1:0]       chan_id;
    logic [DEPTH_W-1:0]         depth;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [COUNT_W-1:0]         hist_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [SAMPLE_W-1:0] data_out;
    logic                       data_valid;
    logic [POS_W-1:0]           hist_pos;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic                req_load;
    logic                scan_start;
    logic                scan_run;
    logic                reg_alloc;
    logic                smp_write;
    logic                fresh_clr;
    logic                smp_read;
    logic                hist_init;
    logic                hist_step;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_data;
    logic                out_last;
  } csh_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             depth_bad;
    logic             count_zero;
    logic             hit;
    logic             miss;
    logic             pool_short;
    logic             table_full;
    logic             fresh;
    logic             cnt_zero;
    logic             hist_end;
  } csh_sts_t;

endpackage

// ----- src/csh_if.sv -----
// valid/ready channel interfaces for request and result items
interface csh_in_if;
  import csh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csh_out_if;
  import csh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/csh_ram.sv -----
// generic single-write, single-read ram with registered read data
module csh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- src/csh_ctrl.sv -----
// request sequencer: table scan, action and result emission
module csh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  csh_pkg::csh_sts_t sts,
  output csh_pkg::csh_cmd_t cmd
);
  import csh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_HRD   = 3'd5;
  localparam logic [2:0] S_HEMIT = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic                pend_data_r, pend_data_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                slot_free;

  assign slot_free = !out_vld_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

  always_comb begin
    cmd             = '0;
    state_nxt       = state_r;
    found_nxt       = found_r;
    pend_status_nxt = pend_status_r;
    pend_data_nxt   = pend_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        pend_data_nxt = 1'b0;
        if (sts.req_type == REQ_REGISTER && sts.depth_bad) begin
          pend_status_nxt = ST_BAD_SIZE;
          state_nxt       = S_EMIT;
        end else if (sts.req_type == REQ_HISTORY && sts.count_zero) begin
          pend_status_nxt = ST_BAD_REQ;
          state_nxt       = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          found_nxt = 1'b1;
          state_nxt = S_EXEC;
        end else if (sts.miss) begin
          found_nxt = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        pend_data_nxt = 1'b0;
        state_nxt     = S_EMIT;
        unique case (sts.req_type)
          REQ_REGISTER: begin
            if (found_r) begin
              pend_status_nxt = ST_OK;
            end else if (sts.pool_short) begin
              pend_status_nxt = ST_FULL;
            end else begin
              cmd.reg_alloc   = 1'b1;
              pend_status_nxt = sts.table_full ? ST_FULL : ST_OK;
            end
          end
          REQ_WRITE: begin
            if (found_r) begin
              cmd.smp_write   = 1'b1;
              pend_status_nxt = ST_OK;
            end else begin
              pend_status_nxt = ST_UNKNOWN;
            end
          end
          REQ_LATEST: begin
            if (!found_r) begin
              pend_status_nxt = ST_UNKNOWN;
            end else begin
              cmd.fresh_clr = 1'b1;
              if (sts.fresh) begin
                cmd.smp_read    = 1'b1;
                pend_data_nxt   = 1'b1;
                pend_status_nxt = ST_OK;
              end else begin
                pend_status_nxt = ST_NO_FRESH;
              end
            end
          end
          REQ_HISTORY: begin
            if (!found_r) begin
              pend_status_nxt = ST_UNKNOWN;
            end else if (sts.cnt_zero) begin
              pend_status_nxt = ST_OK;
            end else begin
              cmd.hist_init = 1'b1;
              state_nxt     = S_HRD;
            end
          end
          default: begin
            pend_status_nxt = ST_BAD_REQ;
          end
        endcase
      end
      S_HRD: begin
        cmd.smp_read = 1'b1;
        state_nxt    = S_HEMIT;
      end
      S_HEMIT: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_data   = 1'b1;
          cmd.out_last   = sts.hist_end;
          if (sts.hist_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.hist_step = 1'b1;
            state_nxt     = S_HRD;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = pend_status_r;
          cmd.out_data   = pend_data_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r       <= found_nxt;
    pend_status_r <= pend_status_nxt;
    pend_data_r   <= pend_data_nxt;
  end
endmodule

// ----- src/csh_datapath.sv -----
// channel table, sample pool, address arithmetic and result register
module csh_datapath #(
  parameter int MAX_CHANNELS = csh_pkg::MAX_CHANNELS_DEF,
  parameter int POOL_WORDS   = csh_pkg::POOL_WORDS_DEF,
  parameter int MAX_HISTORY  = csh_pkg::MAX_HISTORY_DEF,
  parameter int DATA_WIDTH   = csh_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csh_pkg::in_item_t  in_item,
  input  csh_pkg::csh_cmd_t  cmd,
  output csh_pkg::csh_sts_t  sts,
  output csh_pkg::out_item_t out_item
);
  import csh_pkg::*;

  localparam int EIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EUW   = $clog2(MAX_CHANNELS + 1);
  localparam int PAW   = $clog2(POOL_WORDS);
  localparam int PNW   = $clog2(POOL_WORDS + 1);
  localparam int PCW   = ((PNW > DEPTH_W) ? PNW : DEPTH_W) + 1;
  localparam int DEPW  = $clog2(MAX_HISTORY + 1);
  localparam int HEADW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int SW    = DEPW + 1;
  localparam int AW    = (PAW > SW) ? PAW : SW;
  localparam int ENTW  = CHAN_ID_W + PAW + DEPW + HEADW + DEPW + 1;

  in_item_t             req_r;
  logic [EUW-1:0]       entries_used_r;
  logic [EUW-1:0]       scan_idx_r;
  logic [PNW-1:0]       pool_next_r;
  logic                 dv_r;
  logic [EIW-1:0]       dv_idx_r;
  logic [ENTW-1:0]      ent_r;
  logic [EIW-1:0]       ent_idx_r;
  logic [CNT_W-1:0]     hist_idx_r;
  logic [CNT_W-1:0]     hist_cnt_r;
  out_item_t            out_r;

  logic [ENTW-1:0]      ent_rdata, ent_wdata;
  logic [EIW-1:0]       ent_waddr;
  logic                 ent_we, ent_re;
  logic [CHAN_ID_W-1:0] rd_key;
  logic                 key_match, scan_hit, scan_miss, table_full;

  logic [CHAN_ID_W-1:0] ent_key;
  logic [PAW-1:0]       ent_base;
  logic [DEPW-1:0]      ent_depth, ent_fill, fill_new, head_inc;
  logic [HEADW-1:0]     ent_head, head_new;
  logic                 ent_fresh;

  logic [PCW-1:0]       pool_sum;
  logic [SW-1:0]        slot_sum, slot_idx;
  logic [DEPTH_W-1:0]   fill_ext, hist_min;
  logic [CNT_W-1:0]     hist_cnt_c;

  logic                 smp_we, smp_re;
  logic [PAW-1:0]       smp_waddr, smp_raddr;
  logic [DATA_WIDTH-1:0] smp_wdata, smp_rdata;

  assign {ent_key, ent_base, ent_depth, ent_head, ent_fill, ent_fresh} = ent_r;
  assign rd_key = ent_rdata[ENTW-1 -: CHAN_ID_W];

  // table scan, one entry per cycle through the registered read port
  assign ent_re     = cmd.scan_run && (scan_idx_r < entries_used_r);
  assign key_match  = (rd_key == req_r.chan_id);
  assign scan_hit   = cmd.scan_run && dv_r && key_match;
  assign scan_miss  = (entries_used_r == '0) ||
                      (dv_r && !key_match && ((EUW'(dv_idx_r) + EUW'(1)) == entries_used_r));
  assign table_full = (entries_used_r == EUW'(MAX_CHANNELS));

  assign pool_sum = PCW'(pool_next_r) + PCW'(req_r.depth);

  assign head_inc = DEPW'(ent_head) + DEPW'(1);
  assign head_new = (head_inc == ent_depth) ? {HEADW{1'b0}} : head_inc[HEADW-1:0];
  assign fill_new = (ent_fill < ent_depth) ? ent_fill + DEPW'(1) : ent_fill;

  // ring slot of the sample that is hist_idx_r writes old
  assign slot_sum = SW'(ent_head) + SW'(ent_depth) - SW'(1) - SW'(hist_idx_r);
  assign slot_idx = (slot_sum >= SW'(ent_depth)) ? slot_sum - SW'(ent_depth) : slot_sum;

  assign fill_ext   = DEPTH_W'(ent_fill);
  assign hist_min   = (req_r.hist_count < fill_ext) ? req_r.hist_count : fill_ext;
  assign hist_cnt_c = (hist_min > DEPTH_W'(RESULT_CAP)) ? CNT_W'(RESULT_CAP)
                                                       : hist_min[CNT_W-1:0];

  always_comb begin
    ent_we    = (cmd.reg_alloc && !table_full) || cmd.smp_write || cmd.fresh_clr;
    ent_waddr = cmd.reg_alloc ? entries_used_r[EIW-1:0] : ent_idx_r;
    priority if (cmd.reg_alloc) begin
      ent_wdata = {req_r.chan_id, pool_next_r[PAW-1:0], req_r.depth[DEPW-1:0],
                   {HEADW{1'b0}}, {DEPW{1'b0}}, 1'b0};
    end else if (cmd.smp_write) begin
      ent_wdata = {ent_key, ent_base, ent_depth, head_new, fill_new, 1'b1};
    end else begin
      ent_wdata = {ent_key, ent_base, ent_depth, ent_head, ent_fill, 1'b0};
    end
  end

  assign smp_we    = cmd.smp_write;
  assign smp_re    = cmd.smp_read;
  assign smp_waddr = PAW'(AW'(ent_base) + AW'(ent_head));
  assign smp_raddr = PAW'(AW'(ent_base) + AW'(slot_idx));
  assign smp_wdata = DATA_WIDTH'($unsigned(req_r.sample_value));

  csh_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_CHANNELS)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (scan_idx_r[EIW-1:0]),
    .rdata (ent_rdata)
  );

  csh_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (POOL_WORDS)
  ) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (smp_wdata),
    .re    (smp_re),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= '0;
      pool_next_r    <= '0;
      dv_r           <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        dv_r <= 1'b0;
      end else if (cmd.scan_run) begin
        dv_r <= ent_re;
      end
      if (cmd.reg_alloc) begin
        pool_next_r <= pool_sum[PNW-1:0];
        if (!table_full) begin
          entries_used_r <= entries_used_r + EUW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r      <= in_item;
      hist_idx_r <= '0;
    end else if (cmd.hist_step) begin
      hist_idx_r <= hist_idx_r + CNT_W'(1);
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (ent_re) begin
      scan_idx_r <= scan_idx_r + EUW'(1);
      dv_idx_r   <= scan_idx_r[EIW-1:0];
    end
    if (scan_hit) begin
      ent_r     <= ent_rdata;
      ent_idx_r <= dv_idx_r;
    end
    if (cmd.hist_init) begin
      hist_cnt_r <= hist_cnt_c;
    end
    if (cmd.out_load) begin
      out_r.status     <= cmd.out_status;
      out_r.data_out   <= cmd.out_data ? SAMPLE_W'(smp_rdata) : '0;
      out_r.data_valid <= cmd.out_data;
      out_r.hist_pos   <= cmd.out_data ? POS_W'(hist_idx_r) : '0;
      out_r.last       <= cmd.out_last;
    end
  end

  assign sts.req_type   = req_r.req_type;
  assign sts.depth_bad  = (req_r.depth == '0) || (req_r.depth > DEPTH_W'(MAX_HISTORY));
  assign sts.count_zero = (req_r.hist_count == '0);
  assign sts.hit        = scan_hit;
  assign sts.miss       = scan_miss;
  assign sts.pool_short = (pool_sum > PCW'(POOL_WORDS));
  assign sts.table_full = table_full;
  assign sts.fresh      = ent_fresh;
  assign sts.cnt_zero   = (hist_cnt_c == '0);
  assign sts.hist_end   = ((hist_idx_r + CNT_W'(1)) == hist_cnt_r);

  assign out_item = out_r;
endmodule

// ----- src/channel_sample_history_store_top.sv -----
// a bad depth or zero count is answered straight after the request check, with no table scan; other requests
// scan the table first, ending at the hit entry or after the last registered channel, and a history
// request then reads its first sample; the scan checks one table entry a cycle
// history requests then give each result by a sample ram read, then an emit that waits for a free output register
// next request is taken once the current one has handed its last result to the output register
// reset (synchronous, active low) empties the table and pool; no clearing pass
module channel_sample_history_store_top #(
  parameter int MAX_CHANNELS = csh_pkg::MAX_CHANNELS_DEF,
  parameter int POOL_WORDS   = csh_pkg::POOL_WORDS_DEF,
  parameter int MAX_HISTORY  = csh_pkg::MAX_HISTORY_DEF,
  parameter int DATA_WIDTH   = csh_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  csh_in_if.sink    in_ch,
  csh_out_if.source out_ch
);
  import csh_pkg::*;

  csh_cmd_t cmd;
  csh_sts_t sts;

  csh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csh_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .POOL_WORDS   (POOL_WORDS),
    .MAX_HISTORY  (MAX_HISTORY),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_ch.data)
  );
endmodule

// ----- src/csh_checker.sv -----
// port-level assertions for the channel sample history store, bound to the top level
`include "channel_sample_history_store_top_macros.svh"

module csh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input csh_pkg::out_item_t out_item
);
  import csh_pkg::*;

  `CSH_ASSERT_RESET(a_no_result_after_reset, !out_valid, "result valid right after reset")

  `CSH_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result item dropped or changed")

  `CSH_ASSERT_NOW(a_empty_result_zero, out_valid && !out_item.data_valid, (out_item.data_out == '0) && (out_item.hist_pos == '0), "result without sample carries nonzero data or position")

  `CSH_ASSERT_NOW(a_sample_only_ok, out_valid && out_item.data_valid, out_item.status == ST_OK, "sample returned with an error status")

  `CSH_ASSERT_NOW(a_error_is_last, out_valid && (out_item.status != ST_OK), out_item.last, "error result not marked last")
endmodule

bind channel_sample_history_store_top csh_checker u_csh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.data)
);

// ----- bench/tb.sv -----
// testbench for the channel sample history store: directed and random requests
`timescale 1ns / 1ps

module tb;
  import csh_pkg::*;

  localparam int NUM_CHAN  = MAX_CHANNELS_DEF;
  localparam int POOL_SIZE = POOL_WORDS_DEF;
  localparam int RING_MAX  = MAX_HISTORY_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;

  typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  csh_in_if  in_if ();
  csh_out_if out_if ();

  channel_sample_history_store_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predicted store contents
  logic [CHAN_ID_W-1:0]       ch_key   [NUM_CHAN];
  logic [7:0]                 ch_base  [NUM_CHAN];
  logic [DEPTH_W-1:0]         ch_depth [NUM_CHAN];
  logic [POS_W-1:0]           wr_head  [NUM_CHAN];
  logic [DEPTH_W-1:0]         ch_fill  [NUM_CHAN];
  logic                       ch_fresh [NUM_CHAN];
  logic [4:0]                 chans_used;
  logic [8:0]                 pool_next;
  logic signed [SAMPLE_W-1:0] sample_ram [POOL_SIZE];

  out_item_t due_replies[$];
  int        fail_count;
  int        burst_left;
  int        quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_chan(logic [CHAN_ID_W-1:0] id);
    for (int i = 0; i < chans_used; i++)
      if (ch_key[i] == id) return i;
    return -1;
  endfunction

  function automatic int ring_addr(int e, int age);
    int d;
    int idx;
    d = int'(ch_depth[e]);
    idx = (int'(wr_head[e]) + d - 1 - age) % d;
    return (int'(ch_base[e]) + idx) % POOL_SIZE;
  endfunction

  function automatic void predict_replies(in_item_t rq);
    out_item_t r;
    int        e;
    int        cnt;
    bit        streamed;
    r = '0;
    r.last = 1'b1;
    streamed = 1'b0;
    e = find_chan(rq.chan_id);
    if (rq.req_type == REQ_REGISTER) begin
      if (rq.depth < 1 || rq.depth > RING_MAX) begin
        r.status = ST_BAD_SIZE;
      end else if (e >= 0) begin
        r.status = ST_OK;
      end else if (int'(pool_next) + int'(rq.depth) > POOL_SIZE) begin
        r.status = ST_FULL;
      end else begin
        if (chans_used >= NUM_CHAN) begin
          r.status = ST_FULL;
        end else begin
          ch_key[chans_used[3:0]]   = rq.chan_id;
          ch_base[chans_used[3:0]]  = pool_next[7:0];
          ch_depth[chans_used[3:0]] = rq.depth;
          wr_head[chans_used[3:0]]  = '0;
          ch_fill[chans_used[3:0]]  = '0;
          ch_fresh[chans_used[3:0]] = 1'b0;
          chans_used = chans_used + 5'd1;
          r.status = ST_OK;
        end
        pool_next = pool_next + 9'(rq.depth);
      end
    end else if (rq.req_type == REQ_HISTORY && rq.hist_count == 0) begin
      r.status = ST_BAD_REQ;
    end else if (e < 0) begin
      r.status = ST_UNKNOWN;
    end else if (rq.req_type == REQ_WRITE) begin
      sample_ram[(int'(ch_base[e]) + int'(wr_head[e])) % POOL_SIZE] = rq.sample_value;
      wr_head[e] = POS_W'((int'(wr_head[e]) + 1) % int'(ch_depth[e]));
      if (ch_fill[e] < ch_depth[e]) ch_fill[e] = ch_fill[e] + DEPTH_W'(1);
      ch_fresh[e] = 1'b1;
      r.status = ST_OK;
    end else if (rq.req_type == REQ_LATEST) begin
      if (!ch_fresh[e]) begin
        r.status = ST_NO_FRESH;
      end else begin
        r.status = ST_OK;
        r.data_out = sample_ram[ring_addr(e, 0)];
        r.data_valid = 1'b1;
      end
      ch_fresh[e] = 1'b0;
    end else begin
      cnt = int'((rq.hist_count < ch_fill[e]) ? rq.hist_count : ch_fill[e]);
      if (cnt > RESULT_CAP) cnt = RESULT_CAP;
      r.status = ST_OK;
      if (cnt > 0) begin
        streamed = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          r.data_out = sample_ram[ring_addr(e, i)];
          r.data_valid = 1'b1;
          r.hist_pos = POS_W'(i);
          r.last = (i == cnt - 1);
          due_replies.push_back(r);
        end
      end
    end
    if (!streamed) due_replies.push_back(r);
  endfunction

  function automatic in_item_t req_item(logic [REQ_W-1:0] kind, logic [CHAN_ID_W-1:0] id,
                                        logic [DEPTH_W-1:0] dep, logic [SAMPLE_W-1:0] val,
                                        logic [COUNT_W-1:0] n);
    in_item_t it;
    it.req_type = kind;
    it.chan_id = id;
    it.depth = dep;
    it.sample_value = val;
    it.hist_count = n;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input in_item_t it);
    int gap;
    begin
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_if.valid <= 1'b1;
      in_if.data <= it;
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      predict_replies(it);
      burst_left--;
      @(negedge clk);
    end
  endtask

  task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
    begin
      fail_count++;
      if (fail_count <= 10)
        $display("%s: exp st=%0d d=%h v=%b pos=%0d last=%b, got st=%0d d=%h v=%b pos=%0d last=%b",
                 what, want.status, want.data_out, want.data_valid, want.hist_pos, want.last,
                 got.status, got.data_out, got.data_valid, got.hist_pos, got.last);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (due_replies.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = due_replies.pop_front();
        if (got.status !== want.status || got.data_out !== want.data_out ||
            got.data_valid !== want.data_valid || got.hist_pos !== want.hist_pos ||
            got.last !== want.last)
          note_failure("result mismatch", want, got);
      end
    end
  end

  initial begin : result_stall
    rx_mode_t    mode;
    int          phase_left;
    logic [31:0] pat;
    mode = RX_STEADY;
    phase_left = 0;
    pat = '0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(8, 64);
        pat = $urandom;
      end
      phase_left--;
      case (mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          out_if.ready <= pat[0];
          pat = {pat[0], pat[31:1]};
        end
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic test_unknown_and_malformed();
    begin
      send_req(req_item(REQ_WRITE, 16'h0000, 7'd0, 32'h0000_0001, 7'd0));
      send_req(req_item(REQ_HISTORY, 16'h0000, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_LATEST, 16'hFFFF, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_HISTORY, 16'hFFFF, 7'd0, 32'h0, 7'd127));
      send_req(req_item(REQ_REGISTER, 16'h0000, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, 16'h0000, 7'd17, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 7'd127));
    end
  endtask

  task automatic test_ring_basics();
    begin
      send_req(req_item(REQ_REGISTER, 16'hFFFF, 7'd16, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, 16'hFFFF, 7'd3, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, 16'hFFFF, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, 16'h0000, 7'd1, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, 16'h1234, 7'd3, 32'h0, 7'd0));
      send_req(req_item(REQ_HISTORY, 16'hFFFF, 7'd0, 32'h0, 7'd5));
      send_req(req_item(REQ_LATEST, 16'hFFFF, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_HISTORY, 16'hFFFF, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_WRITE, 16'hFFFF, 7'd0, 32'h7FFF_FFFF, 7'd0));
      send_req(req_item(REQ_WRITE, 16'hFFFF, 7'd0, 32'h8000_0000, 7'd0));
      send_req(req_item(REQ_LATEST, 16'hFFFF, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_LATEST, 16'hFFFF, 7'd0, 32'h0, 7'd0));
      send_req(req_item(REQ_WRITE, 16'h1234, 7'd0, 32'hFFFF_FFFF, 7'd0));
      send_req(req_item(REQ_WRITE, 16'h1234, 7'd0, 32'h0000_0000, 7'd0));
      send_req(req_item(REQ_WRITE, 16'h1234, 7'd0, 32'h0000_0001, 7'd0));
      send_req(req_item(REQ_WRITE, 16'h1234, 7'd0, 32'h5A5A_A5A5, 7'd0));
      send_req(req_item(REQ_HISTORY, 16'h1234, 7'd0, 32'h0, 7'd127));
      send_req(req_item(REQ_WRITE, 16'h0000, 7'd0, 32'h1111_1111, 7'd0));
      send_req(req_item(REQ_WRITE, 16'h0000, 7'd0, 32'h2222_2222, 7'd0));
      send_req(req_item(REQ_HISTORY, 16'h0000, 7'd0, 32'h0, 7'd1));
      send_req(req_item(REQ_HISTORY, 16'hFFFF, 7'd0, 32'h0, 7'd1));
    end
  endtask

  task automatic test_random_traffic(input int count);
    in_item_t it;
    int       pick;
    begin
      for (int k = 0; k < count; k++) begin
        it = req_item(REQ_WRITE, 16'h0, 7'd0, $urandom, 7'd0);
        pick = $urandom_range(0, 99);
        if (pick < 70 && chans_used > 0)
          it.chan_id = ch_key[$urandom_range(0, chans_used - 1)];
        else if (pick < 88)
          it.chan_id = 16'h0100 + CHAN_ID_W'($urandom_range(0, 23));
        else
          it.chan_id = CHAN_ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          it.req_type = REQ_REGISTER;
          pick = $urandom_range(0, 9);
          if (pick == 0) it.depth = 7'd0;
          else if (pick == 1) it.depth = DEPTH_W'($urandom_range(RING_MAX + 1, 127));
          else it.depth = DEPTH_W'($urandom_range(1, RING_MAX));
        end else if (pick < 50) begin
          if ($urandom_range(0, 9) == 0)
            it.sample_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (pick < 70) begin
          it.req_type = REQ_LATEST;
        end else begin
          it.req_type = REQ_HISTORY;
          pick = $urandom_range(0, 19);
          if (pick == 0) it.hist_count = 7'd0;
          else if (pick < 5) it.hist_count = COUNT_W'($urandom_range(0, 127));
          else it.hist_count = COUNT_W'($urandom_range(1, 20));
        end
        if ($urandom_range(0, 7) == 0) begin
          it.depth = DEPTH_W'($urandom) | it.depth;
          if (it.req_type != REQ_HISTORY) it.hist_count = COUNT_W'($urandom);
        end
        send_req(it);
      end
    end
  endtask

  task automatic test_table_and_pool_limits();
    int k;
    int room;
    begin
      k = 0;
      while (pool_next < POOL_SIZE) begin
        while (find_chan(16'hA500 + CHAN_ID_W'(k)) >= 0) k++;
        room = POOL_SIZE - int'(pool_next);
        send_req(req_item(REQ_REGISTER, 16'hA500 + CHAN_ID_W'(k),
                          DEPTH_W'((room > RING_MAX) ? RING_MAX : room), 32'h0, 7'd0));
        k++;
      end
      while (find_chan(16'hA500 + CHAN_ID_W'(k)) >= 0) k++;
      send_req(req_item(REQ_REGISTER, 16'hA500 + CHAN_ID_W'(k), 7'd1, 32'h0, 7'd0));
      send_req(req_item(REQ_REGISTER, ch_key[0], 7'd2, 32'h0, 7'd0));
      for (int i = 0; i < 6; i++) begin
        send_req(req_item(REQ_WRITE, ch_key[NUM_CHAN - 1], 7'd0, $urandom, 7'd0));
        send_req(req_item(REQ_HISTORY, ch_key[NUM_CHAN - 1], 7'd0, 32'h0, 7'd127));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    fail_count = 0;
    burst_left = 0;
    quiet_cycles = 0;
    chans_used = '0;
    pool_next = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      ch_key[i] = '0;
      ch_base[i] = '0;
      ch_depth[i] = '0;
      wr_head[i] = '0;
      ch_fill[i] = '0;
      ch_fresh[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) sample_ram[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unknown_and_malformed();
    test_ring_basics();
    test_random_traffic(470);
    test_table_and_pool_limits();

    in_if.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_replies.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/csh_pkg.sv
src/csh_if.sv
src/csh_ram.sv
src/csh_ctrl.sv
src/csh_datapath.sv
src/channel_sample_history_store_top.sv
src/csh_checker.sv
bench/tb.sv
